// ===== src/sedp_pkg.sv =====
// Shared types, codes and reset constants for the slot edge peak detector.
package sedp_pkg;

    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_NEG  = 2'd1,
        PH_POS  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_READ = 2'd1,
        SQ_EMIT = 2'd2
    } seq_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_SLOT    = 3'd2;
    localparam logic [2:0] KIND_REPORT  = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    localparam logic [2:0] REG_AMBIENT = 3'd0;
    localparam logic [2:0] REG_LOWER   = 3'd1;
    localparam logic [2:0] REG_UPPER   = 3'd2;
    localparam logic [2:0] REG_END_GAP = 3'd3;
    localparam logic [2:0] REG_OFFSET  = 3'd4;

    localparam logic [9:0]         AMBIENT_RST = 10'd40;
    localparam logic signed [10:0] LOWER_RST   = 11'sd100;
    localparam logic signed [10:0] UPPER_RST   = 11'sd400;
    localparam logic [15:0]        END_GAP_RST = 16'd200;
    localparam logic signed [15:0] OFFSET_RST  = 16'sd0;

endpackage

// ===== src/sedp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sedp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/slot_edge_peak_detector_top.sv =====
// Slot edge peak detector: top level with phase tracking, slot store and end report.
//
// Each input beat gives one result beat, but one that ends a board with slots stored
// gives the end report instead; the next input beat is taken once the output register
// is free and no end report runs. The end of a board walks the slot store through the
// single read port of the RAM, reading then emitting each stored slot (an emit waits for
// a free output register), with s_tready low throughout. A result is held in one output
// register, so a stalled m_tready stalls the input only once that register is full.
module slot_edge_peak_detector_top #(
    parameter int SLOT_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // [9:0] sample, [41:10] position, rest zero
    input  logic [0:0]  s_tuser,  // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // [31:0] slot_position, [42:32] peak_level,
                                  // [48:43] slot_count, [49] overflow, rest zero
    output logic [2:0]  m_tuser,  // [2:0] kind
    output logic        m_tlast
);

    import sedp_pkg::*;

    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    // configuration
    logic [9:0]         ambient_reg;
    logic signed [10:0] lower_reg;
    logic signed [10:0] upper_reg;
    logic [15:0]        end_gap_reg;
    logic signed [15:0] offset_reg;

    // detector state
    phase_t             phase_reg, phase_next;
    logic signed [31:0] trig_pos_reg, trig_pos_next;
    logic signed [10:0] peak_resp_reg, peak_resp_next;
    logic signed [31:0] peak_pos_reg, peak_pos_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               done_reg, done_next;
    logic               dropped_reg, dropped_next;

    // report sequencer
    seq_t               seq_reg, seq_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;

    // output register
    logic               out_valid_reg;
    logic [2:0]         out_kind_reg;
    logic signed [31:0] out_pos_reg;
    logic signed [10:0] out_peak_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    // item datapath
    logic               accept;
    logic               out_free;
    logic               opcode;
    logic [9:0]         sample;
    logic signed [31:0] position;
    logic signed [10:0] resp;
    logic signed [32:0] travel;
    logic [2:0]         res_kind;
    logic signed [31:0] res_pos;
    logic signed [10:0] res_peak;
    logic               start_report;
    logic               ram_we;
    logic               ram_re;
    logic [31:0]        ram_rdata;
    logic               last_entry;
    logic               emit_entry;
    logic [6:0]         count_wide;
    logic [6:0]         count_now_wide;
    logic signed [31:0] report_pos;

    assign opcode   = s_tuser[0];
    assign sample   = s_tdata[9:0];
    assign position = s_tdata[41:10];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (seq_reg == SQ_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign resp   = $signed({1'b0, sample}) - $signed({1'b0, ambient_reg});
    assign travel = $signed({position[31], position}) - $signed({trig_pos_reg[31], trig_pos_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= AMBIENT_RST;
            lower_reg   <= LOWER_RST;
            upper_reg   <= UPPER_RST;
            end_gap_reg <= END_GAP_RST;
            offset_reg  <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AMBIENT: ambient_reg <= cfg_data[9:0];
                REG_LOWER:   lower_reg   <= $signed(cfg_data[10:0]);
                REG_UPPER:   upper_reg   <= $signed(cfg_data[10:0]);
                REG_END_GAP: end_gap_reg <= cfg_data;
                REG_OFFSET:  offset_reg  <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    // per-beat detector step
    always_comb
    begin
        phase_next     = phase_reg;
        trig_pos_next  = trig_pos_reg;
        peak_resp_next = peak_resp_reg;
        peak_pos_next  = peak_pos_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        dropped_next   = dropped_reg;
        res_kind       = KIND_NONE;
        res_pos        = '0;
        res_peak       = '0;
        start_report   = 1'b0;
        ram_we         = 1'b0;

        if (opcode == OP_CLEAR)
        begin
            count_next   = '0;
            done_next    = 1'b0;
            dropped_next = 1'b0;
            phase_next   = PH_WAIT;
        end
        else if (done_reg)
        begin
            res_kind = KIND_IGNORED;
        end
        else
        begin
            case (phase_reg)
                PH_NEG:
                begin
                    if (resp > upper_reg)
                    begin
                        phase_next     = PH_POS;
                        trig_pos_next  = position;
                        peak_resp_next = '0;
                        peak_pos_next  = '0;
                    end
                end
                PH_POS:
                begin
                    if (resp > peak_resp_reg)
                    begin
                        peak_resp_next = resp;
                        peak_pos_next  = position;
                    end
                    if (resp < lower_reg)
                    begin
                        phase_next    = PH_NEG;
                        trig_pos_next = position;
                        if (count_reg < CW'(SLOT_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                        res_kind = KIND_SLOT;
                        res_pos  = peak_pos_next;
                        res_peak = peak_resp_next;
                    end
                    else if (travel > $signed({17'd0, end_gap_reg}))
                    begin
                        phase_next    = PH_WAIT;
                        trig_pos_next = position;
                        done_next     = 1'b1;
                        if (count_reg == '0)
                        begin
                            res_kind = KIND_REPORT;
                        end
                        else
                        begin
                            start_report = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // wait for board start; the unused code lands here too
                    phase_next = PH_WAIT;
                    if (resp < lower_reg)
                    begin
                        phase_next    = PH_NEG;
                        trig_pos_next = position;
                        res_kind      = KIND_START;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            trig_pos_reg  <= '0;
            peak_resp_reg <= '0;
            peak_pos_reg  <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            trig_pos_reg  <= trig_pos_next;
            peak_resp_reg <= peak_resp_next;
            peak_pos_reg  <= peak_pos_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            dropped_reg   <= dropped_next;
        end
    end

    sedp_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (peak_pos_next),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign last_entry = (CW'(rd_idx_reg + CW'(1)) == count_reg);
    assign emit_entry = (seq_reg == SQ_EMIT) && out_free;

    // report sequencer: next state
    always_comb
    begin
        seq_next    = seq_reg;
        rd_idx_next = rd_idx_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept && start_report)
                begin
                    seq_next    = SQ_READ;
                    rd_idx_next = '0;
                end
            end
            SQ_READ:
            begin
                seq_next = SQ_EMIT;
            end
            SQ_EMIT:
            begin
                if (out_free)
                begin
                    rd_idx_next = CW'(rd_idx_reg + CW'(1));
                    seq_next    = last_entry ? SQ_IDLE : SQ_READ;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // report sequencer: outputs
    always_comb
    begin
        ram_re = 1'b0;
        case (seq_reg)
            SQ_READ: ram_re = 1'b1;
            default: ram_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SQ_IDLE;
            rd_idx_reg <= '0;
        end
        else
        begin
            seq_reg    <= seq_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign count_wide     = 7'(count_next);
    assign count_now_wide = 7'(count_reg);
    assign report_pos     = $signed(ram_rdata) + 32'(offset_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !start_report) || emit_entry)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !start_report)
        begin
            out_kind_reg  <= res_kind;
            out_pos_reg   <= res_pos;
            out_peak_reg  <= res_peak;
            out_count_reg <= count_wide[COUNT_W-1:0];
            out_ovf_reg   <= dropped_next;
            out_last_reg  <= 1'b1;
        end
        else if (emit_entry)
        begin
            out_kind_reg  <= KIND_REPORT;
            out_pos_reg   <= report_pos;
            out_peak_reg  <= '0;
            out_count_reg <= count_now_wide[COUNT_W-1:0];
            out_ovf_reg   <= dropped_reg;
            out_last_reg  <= last_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_ovf_reg, out_count_reg, out_peak_reg, out_pos_reg};

`ifndef SYNTHESIS
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ram_we) |-> (count_reg < CW'(SLOT_DEPTH)))
        else $error("slot store written beyond its depth");

    a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_IDLE) |-> (count_reg != '0 && rd_idx_reg < count_reg))
        else $error("report walks past the stored slots");

    a_report_beat: assert property (@(posedge clk) disable iff (!rst_n)
        emit_entry |=> (out_valid_reg && out_kind_reg == KIND_REPORT))
        else $error("report entry not loaded into output register");

    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_IDLE) |-> done_reg)
        else $error("report running while board not done");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the slot edge peak detector: directed and random boards.
module tb_top;
    import sedp_pkg::*;

    localparam int SLOT_DEPTH    = 32;
    localparam int RANDOM_ITEMS  = 100;
    localparam int DRAIN_CYCLES  = 100;   // a full end report walks the store, reading then emitting each slot
    localparam int LONG_HOLD     = 150;
    localparam int WATCHDOG      = 3000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] pos;
        logic [10:0] level;
        logic [5:0]  count;
        logic        ovf;
        logic        last;
    } beat_t;

    class slot_report_scoreboard;
        // register copies
        int amb_lvl  = 40;
        int lo_trig  = 100;
        int hi_trig  = 400;
        int gap_len  = 200;
        int align_off = 0;

        phase_t  scan_phase = PH_WAIT;
        longint  trig_pos;
        int      peak_resp;
        longint  peak_pos;
        int      stored;
        bit      board_done;
        bit      dropped;
        longint  slot_pos_store [SLOT_DEPTH];

        beat_t   pending_results [$];
        int      errors;
        int      n_in, n_out, n_slot, n_report, n_drop_flag;

        function void set_cfg(int amb, int lo, int hi, int gap, int off);
            amb_lvl   = amb;
            lo_trig   = lo;
            hi_trig   = hi;
            gap_len   = gap;
            align_off = off;
        endfunction

        function void push(logic [2:0] kind, longint pos, int lvl, bit last);
            beat_t b;
            b.kind  = kind;
            b.pos   = pos[31:0];
            b.level = lvl[10:0];
            b.count = stored[5:0];
            b.ovf   = dropped;
            b.last  = last;
            pending_results.push_back(b);
        endfunction

        // one accepted input beat -> expected result beats
        function void note_input(logic op, logic [9:0] smp, logic [31:0] raw_pos);
            int     resp;
            longint p;
            resp = int'(smp) - amb_lvl;
            p    = longint'(signed'(raw_pos));
            n_in++;
            if (op == OP_CLEAR) begin
                stored     = 0;
                board_done = 0;
                dropped    = 0;
                scan_phase = PH_WAIT;
                push(KIND_NONE, 0, 0, 1);
                return;
            end
            if (board_done) begin
                push(KIND_IGNORED, 0, 0, 1);
                return;
            end
            case (scan_phase)
                PH_NEG: begin
                    if (resp > hi_trig) begin
                        scan_phase = PH_POS;
                        trig_pos   = p;
                        peak_resp  = 0;
                        peak_pos   = 0;
                    end
                    push(KIND_NONE, 0, 0, 1);
                end
                PH_POS: begin
                    if (resp > peak_resp) begin
                        peak_resp = resp;
                        peak_pos  = p;
                    end
                    if (resp < lo_trig) begin
                        scan_phase = PH_NEG;
                        trig_pos   = p;
                        if (stored < SLOT_DEPTH) begin
                            slot_pos_store[stored] = peak_pos;
                            stored++;
                        end
                        else
                            dropped = 1;
                        push(KIND_SLOT, peak_pos, peak_resp, 1);
                    end
                    else if (p - trig_pos > longint'(gap_len)) begin
                        // board end: dump the store, offset applied, 32-bit wrap
                        scan_phase = PH_WAIT;
                        trig_pos   = p;
                        board_done = 1;
                        if (stored == 0)
                            push(KIND_REPORT, 0, 0, 1);
                        else
                            for (int i = 0; i < stored; i++)
                                push(KIND_REPORT, slot_pos_store[i] + align_off, 0,
                                     i + 1 == stored);
                    end
                    else
                        push(KIND_NONE, 0, 0, 1);
                end
                default: begin
                    scan_phase = PH_WAIT;
                    if (resp < lo_trig) begin
                        scan_phase = PH_NEG;
                        trig_pos   = p;
                        push(KIND_START, 0, 0, 1);
                    end
                    else
                        push(KIND_NONE, 0, 0, 1);
                end
            endcase
        endfunction

        function void cmp(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(beat_t got);
            beat_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual kind %0d pos %0h",
                         $time, got.kind, got.pos);
                return;
            end
            want = pending_results.pop_front();
            n_out++;
            if (want.kind == KIND_SLOT)
                n_slot++;
            if (want.kind == KIND_REPORT)
                n_report++;
            if (want.ovf)
                n_drop_flag++;
            cmp("kind", want.kind, got.kind);
            cmp("slot_position", want.pos, got.pos);
            cmp("peak_level", want.level, got.level);
            cmp("slot_count", want.count, got.count);
            cmp("overflow", want.ovf, got.ovf);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    slot_report_scoreboard sb = new();
    bit quiet;          // no idling on either side
    bit hold_req;       // ask the result side for one long hold-off
    int n_settings;
    int stall_cycles;

    slot_edge_peak_detector_top #(.SLOT_DEPTH(SLOT_DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin : watch_results
        beat_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.pos   = m_tdata[31:0];
            got.level = m_tdata[42:32];
            got.count = m_tdata[48:43];
            got.ovf   = m_tdata[49];
            got.last  = m_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // result side: random back-pressure, calm windows, one long hold on request
    initial
    begin : result_ready
        int cyc;
        cyc = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && (cyc % 100) >= 30 && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            cyc++;
        end
    end

    task automatic send_item(logic op, logic [9:0] smp, logic [31:0] pos);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, pos, smp};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, smp, pos);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(int amb, int lo, int hi, int gap, int off);
        wait_drained();
        sb.set_cfg(amb, lo, hi, gap, off);
        n_settings++;
        cfg_we    <= 1'b1;
        cfg_index <= REG_AMBIENT;
        cfg_data  <= 16'(amb);
        @(posedge clk);
        cfg_index <= REG_LOWER;
        cfg_data  <= {5'd0, 11'(lo)};
        @(posedge clk);
        cfg_index <= REG_UPPER;
        cfg_data  <= {5'd0, 11'(hi)};
        @(posedge clk);
        cfg_index <= REG_END_GAP;
        cfg_data  <= 16'(gap);
        @(posedge clk);
        cfg_index <= REG_OFFSET;
        cfg_data  <= 16'(off);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // sample whose response falls below the lower trigger, when one exists
    function automatic logic [9:0] shadow_sample();
        int top;
        top = sb.lo_trig + sb.amb_lvl - 1;
        if (top < 0)
            return 10'($urandom);
        if (top > 1023)
            top = 1023;
        return 10'($urandom_range(0, top));
    endfunction

    // sample whose response is above the upper trigger, when one exists
    function automatic logic [9:0] bright_sample();
        int bot;
        bot = sb.hi_trig + sb.amb_lvl + 1;
        if (bot > 1023)
            return 10'($urandom);
        if (bot < 0)
            bot = 0;
        return 10'($urandom_range(bot, 1023));
    endfunction

    function automatic logic [9:0] middle_sample();
        int bot, top;
        bot = sb.lo_trig + sb.amb_lvl;
        top = sb.hi_trig + sb.amb_lvl;
        if (bot < 0)
            bot = 0;
        if (top > 1023)
            top = 1023;
        if (bot > top)
            return 10'($urandom);
        return 10'($urandom_range(bot, top));
    endfunction

    // clear, board start, slots as rise/track/fall, then a long bright run to end it
    task automatic run_board(int slots, bit noisy, int hold_at);
        longint pos;
        int     step_max;
        pos = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
        step_max = sb.gap_len / 4;   // rise to fall stays inside the end gap
        send_item(OP_CLEAR, 10'($urandom), $urandom);
        send_item(OP_SAMPLE, shadow_sample(), 32'(pos));
        for (int k = 0; k < slots; k++) begin
            if (k == hold_at)
                hold_req = 1;
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(1'($urandom), 10'($urandom), $urandom);
            pos += $urandom_range(0, step_max);
            send_item(OP_SAMPLE, bright_sample(), 32'(pos));
            repeat ($urandom_range(0, noisy ? 2 : 0)) begin
                pos += $urandom_range(0, step_max);
                send_item(OP_SAMPLE, $urandom_range(0, 1) ? bright_sample() : middle_sample(),
                          32'(pos));
            end
            pos += $urandom_range(0, step_max);
            send_item(OP_SAMPLE, shadow_sample(), 32'(pos));
        end
        pos += $urandom_range(0, step_max);
        send_item(OP_SAMPLE, bright_sample(), 32'(pos));
        pos += sb.gap_len + 1 + $urandom_range(0, 100);
        send_item(OP_SAMPLE, bright_sample(), 32'(pos));
        repeat ($urandom_range(0, 2))
            send_item(OP_SAMPLE, 10'($urandom), $urandom);
    endtask

    task automatic pick_settings();
        int amb, lo, hi;
        case ($urandom_range(0, 5))
            0: apply_settings(0, -1023, 1023, 0, -32768);
            1: apply_settings(1023, 1023, -1023, 65535, 32767);
            default: begin
                amb = $urandom_range(0, 300);
                lo  = int'($urandom_range(0, 400)) - 100;
                hi  = lo + int'($urandom_range(50, 500));
                if (hi + amb > 1000)
                    hi = 1000 - amb;
                apply_settings(amb, lo, hi,
                               $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 2000),
                               int'($urandom_range(0, 65535)) - 32768);
            end
        endcase
    endtask

    initial
    begin : stimulus
        int n_directed;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // reset settings: 33-bit travel to an empty report, ignored sample, clear, one slot and its report
        send_item(OP_SAMPLE, 10'h3FF, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'h000, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'h3FF, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'h3FF, 32'h7FFF_FFFF);
        send_item(OP_SAMPLE, 10'h000, 32'd5);
        send_item(OP_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 10'd0, 32'd100);
        send_item(OP_SAMPLE, 10'd600, 32'd110);
        send_item(OP_SAMPLE, 10'd1023, 32'd120);
        send_item(OP_SAMPLE, 10'd0, 32'd130);
        send_item(OP_SAMPLE, 10'd1023, 32'd140);
        send_item(OP_SAMPLE, 10'd1023, 32'd341);

        // widest gap, largest offset: report position wraps past the top
        apply_settings(0, 100, 400, 65535, 32767);
        send_item(OP_CLEAR, 10'd0, 32'd0);
        send_item(OP_SAMPLE, 10'd0, 32'd0);
        send_item(OP_SAMPLE, 10'd700, 32'h7FFF_FFF0);
        send_item(OP_SAMPLE, 10'd800, 32'h7FFF_FFF0);
        send_item(OP_SAMPLE, 10'd0, 32'h7FFF_FFF1);
        send_item(OP_SAMPLE, 10'd900, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'd900, 32'h8001_0000);

        // inverted triggers, full ambient, zero gap, most negative offset
        apply_settings(1023, 1023, -1023, 0, -32768);
        send_item(OP_CLEAR, 10'd0, 32'd0);
        send_item(OP_SAMPLE, 10'd0, 32'h8000_0003);
        send_item(OP_SAMPLE, 10'd1, 32'h8000_0003);
        send_item(OP_SAMPLE, 10'd5, 32'h8000_0004);
        n_directed = sb.n_in;

        // store overflow board, with the long result hold-off in the middle of it
        apply_settings($urandom_range(0, 100), 150, 500, 1000, int'($urandom_range(0, 65535)) - 32768);
        run_board(SLOT_DEPTH + 3, 0, 12);

        while (sb.n_in - n_directed < RANDOM_ITEMS) begin
            quiet = (sb.n_in - n_directed) > RANDOM_ITEMS * 4 / 5;
            pick_settings();
            repeat ($urandom_range(1, 2))
                run_board($urandom_range(0, 5), 1, -1);
        end

        quiet = 1;
        wait_drained();
        $display("covered %0d input beats under %0d register settings, %0d result beats",
                 sb.n_in, n_settings, sb.n_out);
        $display("slots found %0d, report entries %0d, beats flagging a dropped slot %0d",
                 sb.n_slot, sb.n_report, sb.n_drop_flag);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
src/sedp_pkg.sv
src/sedp_ram.sv
src/slot_edge_peak_detector_top.sv
bench/tb_top.sv
